/* src/mld_pkg.sv */
// mouse look direction: shared types, constants and lookup functions
// used by the sequencer top level; depends on nothing

package mld_pkg;

  localparam int AtanCount = 24;
  localparam int IterW     = 5;
  localparam int PcW       = 4;

  localparam logic [15:0] GainReset = 16'd6554;
  localparam logic [16:0] YawReset  = 17'd69120;
  localparam logic [16:0] YawFull   = 17'd92160;
  localparam logic [16:0] Deg90     = 17'd23040;
  localparam logic [16:0] Deg180    = 17'd46080;
  localparam logic [16:0] Deg270    = 17'd69120;

  localparam logic signed [15:0] PitchLimit = 16'sd22784;
  localparam logic signed [15:0] DirLimit   = 16'sd16384;
  localparam logic signed [31:0] CordicX0   = 32'sd652032874;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_DELTA_X,
    OP_DELTA_Y,
    OP_WRAP,
    OP_LOAD_YAW,
    OP_ROTATE,
    OP_LOAD_PITCH,
    OP_MUL_X,
    OP_MUL_Z,
    OP_EMIT,
    OP_NOP
  } mld_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_WRAP_BUSY,
    COND_ITER_MORE,
    COND_OUT_BUSY
  } mld_cond_e;

  typedef logic [PcW-1:0] mld_pc_t;
  typedef logic [IterW-1:0] mld_iter_t;

  typedef struct packed {
    mld_op_e   op;
    mld_cond_e cond;
    mld_pc_t   target;
  } mld_uword_t;

  localparam mld_pc_t PcAccept   = 4'd0;
  localparam mld_pc_t PcDeltaX   = 4'd1;
  localparam mld_pc_t PcDeltaY   = 4'd2;
  localparam mld_pc_t PcWrap     = 4'd3;
  localparam mld_pc_t PcLoadYaw  = 4'd4;
  localparam mld_pc_t PcRotYaw   = 4'd5;
  localparam mld_pc_t PcLoadPit  = 4'd6;
  localparam mld_pc_t PcRotPitch = 4'd7;
  localparam mld_pc_t PcMulX     = 4'd8;
  localparam mld_pc_t PcMulZ     = 4'd9;
  localparam mld_pc_t PcEmit     = 4'd10;
  localparam mld_pc_t PcEnd      = 4'd11;

  // control store: a taken condition jumps to target, otherwise pc advances
  function automatic mld_uword_t mld_ucode(mld_pc_t pc);
    mld_uword_t w;
    unique case (pc)
      PcAccept:   w = '{OP_ACCEPT,     COND_NO_ACCEPT, PcAccept};
      PcDeltaX:   w = '{OP_DELTA_X,    COND_NEVER,     PcAccept};
      PcDeltaY:   w = '{OP_DELTA_Y,    COND_NEVER,     PcAccept};
      PcWrap:     w = '{OP_WRAP,       COND_WRAP_BUSY, PcWrap};
      PcLoadYaw:  w = '{OP_LOAD_YAW,   COND_NEVER,     PcAccept};
      PcRotYaw:   w = '{OP_ROTATE,     COND_ITER_MORE, PcRotYaw};
      PcLoadPit:  w = '{OP_LOAD_PITCH, COND_NEVER,     PcAccept};
      PcRotPitch: w = '{OP_ROTATE,     COND_ITER_MORE, PcRotPitch};
      PcMulX:     w = '{OP_MUL_X,      COND_NEVER,     PcAccept};
      PcMulZ:     w = '{OP_MUL_Z,      COND_NEVER,     PcAccept};
      PcEmit:     w = '{OP_EMIT,       COND_OUT_BUSY,  PcEmit};
      PcEnd:      w = '{OP_NOP,        COND_ALWAYS,    PcAccept};
      default:    w = '{OP_NOP,        COND_ALWAYS,    PcAccept};
    endcase
    return w;
  endfunction

  // arctan(2^-i) in degrees, q.20
  function automatic logic [25:0] mld_atan(mld_iter_t i);
    logic [25:0] a;
    unique case (i)
      5'd0:    a = 26'd47185920;
      5'd1:    a = 26'd27855475;
      5'd2:    a = 26'd14718068;
      5'd3:    a = 26'd7471121;
      5'd4:    a = 26'd3750058;
      5'd5:    a = 26'd1876857;
      5'd6:    a = 26'd938658;
      5'd7:    a = 26'd469357;
      5'd8:    a = 26'd234682;
      5'd9:    a = 26'd117342;
      5'd10:   a = 26'd58671;
      5'd11:   a = 26'd29335;
      5'd12:   a = 26'd14668;
      5'd13:   a = 26'd7334;
      5'd14:   a = 26'd3667;
      5'd15:   a = 26'd1833;
      5'd16:   a = 26'd917;
      5'd17:   a = 26'd458;
      5'd18:   a = 26'd229;
      5'd19:   a = 26'd115;
      5'd20:   a = 26'd57;
      5'd21:   a = 26'd29;
      5'd22:   a = 26'd14;
      5'd23:   a = 26'd7;
      default: a = 26'd0;
    endcase
    return a;
  endfunction

  // q.16 degrees to q.8, ties upward
  function automatic logic signed [21:0] mld_delta_round(logic signed [29:0] p);
    logic signed [29:0] r;
    r = (p + 30'sd128) >>> 8;
    return r[21:0];
  endfunction

  // q.60 product to q1.14, ties upward, saturated
  function automatic logic signed [15:0] mld_dir_round(logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [15:0] o;
    r = (p + (64'sd1 <<< 45)) >>> 46;
    if (r > 64'sd16384) begin
      o = DirLimit;
    end else if (r < -64'sd16384) begin
      o = -DirLimit;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage

/* src/mld_if.sv */
// mouse look direction: valid/ready channels for cursor items and
// direction items; no dependencies

interface mld_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;

  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

interface mld_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic        [16:0] yaw_now;
  logic signed [15:0] pitch_now;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output yaw_now, output pitch_now, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input yaw_now, input pitch_now, output ready);
endinterface

/* src/mouse_look_direction_unit.sv */
// mouse look direction: microcoded sequencer with shared cordic datapath
// depends on mld_pkg and the channel interfaces in mld_if
//
// usage: each cursor item on in_i updates yaw and pitch from the movement
// since the previous cursor position, scaled by the mouse_gain register.
// one direction item per cursor item leaves on out_o with the unit view
// vector and both angles. the user writes mouse_gain with mouse_gain_we_i
// only while the block is idle; the block itself does not enforce it.
// the first item after reset gives zero movement. from acceptance to
// output an item passes the delta steps, the yaw wrap step, repeated
// for each 360 degree correction it takes (0 to 12 of them), and two
// cordic passes through the one rotation unit, where CORDIC_STEPS counts
// as at most 24. one item is in work at a time; the next item is taken
// only after the previous result has entered the output register.
// a new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the sequencer holds at the output step
// until the register is free. reset restores yaw to 270 degrees, pitch to
// zero, the gain to its default and drops any pending result.

module mouse_look_direction_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mld_in_if.sink        in_i,
  mld_out_if.source     out_o,
  input  logic          mouse_gain_we_i,
  input  logic [15:0]   mouse_gain_i
);
  import mld_pkg::*;

  localparam int Steps = (CORDIC_STEPS > AtanCount) ? AtanCount : CORDIC_STEPS;
  localparam mld_iter_t LastIter = IterW'(Steps - 1);

  mld_pc_t            pc_q, pc_d;
  mld_uword_t         uw;
  mld_iter_t          iter_q;
  logic               first_q;
  logic [11:0]        prev_x_q, prev_y_q;
  logic [11:0]        cx_q, cy_q;
  logic [15:0]        gain_q;
  logic [16:0]        yaw_q;
  logic signed [15:0] pitch_q;
  logic signed [22:0] t_q;
  logic signed [31:0] x_q, y_q;
  logic signed [29:0] z_q;
  logic               neg_q;
  logic signed [31:0] cos_yaw_q, sin_yaw_q;
  logic signed [63:0] prod_q;
  logic signed [15:0] dir_x_q, dir_y_q;
  logic               out_valid_q;
  logic signed [15:0] out_dx_q, out_dy_q, out_dz_q, out_pitch_q;
  logic [16:0]        out_yaw_q;

  logic               in_acc;
  logic               out_free;
  logic               cond_met;
  logic               wrap_hi, wrap_lo;
  logic signed [12:0] delta;
  logic signed [29:0] delta_prod;
  logic signed [21:0] dlt;
  logic signed [22:0] yaw_sum;
  logic signed [22:0] pitch_diff;
  logic signed [15:0] pitch_d;
  logic signed [17:0] ysel;
  logic               neg_d;
  logic signed [31:0] xs, ys;
  logic signed [29:0] atan_ext;
  logic signed [31:0] mul_c;
  logic signed [63:0] prod_w;
  logic signed [32:0] sin_sum;
  logic signed [32:0] sin_shr;
  logic signed [15:0] dir_y_d;

  assign uw       = mld_ucode(pc_q);
  assign in_i.ready = (uw.op == OP_ACCEPT);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign wrap_hi = (t_q >= $signed({6'b0, YawFull}));
  assign wrap_lo = t_q[22];

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     cond_met = 1'b0;
      COND_ALWAYS:    cond_met = 1'b1;
      COND_NO_ACCEPT: cond_met = !in_acc;
      COND_WRAP_BUSY: cond_met = wrap_hi || wrap_lo;
      COND_ITER_MORE: cond_met = (iter_q != LastIter);
      COND_OUT_BUSY:  cond_met = !out_free;
      default:        cond_met = 1'b1;
    endcase
    pc_d = cond_met ? uw.target : pc_q + 1'b1;
  end

  // shared delta multiplier and angle update
  always_comb begin
    if (uw.op == OP_DELTA_Y) begin
      delta = $signed({1'b0, cy_q}) - $signed({1'b0, prev_y_q});
    end else begin
      delta = $signed({1'b0, cx_q}) - $signed({1'b0, prev_x_q});
    end
    delta_prod = delta * $signed({1'b0, gain_q});
    dlt        = mld_delta_round(delta_prod);
    yaw_sum    = $signed({6'b0, yaw_q}) + {dlt[21], dlt};
    pitch_diff = {{7{pitch_q[15]}}, pitch_q} - {dlt[21], dlt};
    if (pitch_diff > 23'(PitchLimit)) begin
      pitch_d = PitchLimit;
    end else if (pitch_diff < -23'(PitchLimit)) begin
      pitch_d = -PitchLimit;
    end else begin
      pitch_d = pitch_diff[15:0];
    end
  end

  // yaw range reduction into plus or minus 90 degrees
  always_comb begin
    neg_d = 1'b0;
    ysel  = $signed({1'b0, yaw_q});
    if (yaw_q > Deg90 && yaw_q <= Deg270) begin
      ysel  = $signed({1'b0, yaw_q}) - $signed({1'b0, Deg180});
      neg_d = 1'b1;
    end else if (yaw_q > Deg270) begin
      ysel  = $signed({1'b0, yaw_q}) - $signed({1'b0, YawFull});
    end
  end

  assign xs       = x_q >>> iter_q;
  assign ys       = y_q >>> iter_q;
  assign atan_ext = $signed({4'b0, mld_atan(iter_q)});

  assign mul_c  = (uw.op == OP_MUL_Z) ? sin_yaw_q : cos_yaw_q;
  assign prod_w = mul_c * x_q;

  always_comb begin
    sin_sum = {y_q[31], y_q} + 33'sd32768;
    sin_shr = sin_sum >>> 16;
    if (sin_shr > 33'sd16384) begin
      dir_y_d = DirLimit;
    end else if (sin_shr < -33'sd16384) begin
      dir_y_d = -DirLimit;
    end else begin
      dir_y_d = sin_shr[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcAccept;
      iter_q      <= '0;
      first_q     <= 1'b1;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      gain_q      <= GainReset;
      yaw_q       <= YawReset;
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (mouse_gain_we_i) begin
        gain_q <= mouse_gain_i;
      end
      if (out_valid_q && out_o.ready && (uw.op != OP_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (uw.op)
        OP_ACCEPT: begin
          if (in_acc && first_q) begin
            prev_x_q <= in_i.cursor_x;
            prev_y_q <= in_i.cursor_y;
            first_q  <= 1'b0;
          end
        end
        OP_DELTA_X: prev_x_q <= cx_q;
        OP_DELTA_Y: begin
          prev_y_q <= cy_q;
          pitch_q  <= pitch_d;
        end
        OP_WRAP: begin
          if (!wrap_hi && !wrap_lo) begin
            yaw_q <= t_q[16:0];
          end
        end
        OP_LOAD_YAW, OP_LOAD_PITCH: iter_q <= '0;
        OP_ROTATE: iter_q <= iter_q + 1'b1;
        OP_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_ACCEPT: begin
        if (in_acc) begin
          cx_q <= in_i.cursor_x;
          cy_q <= in_i.cursor_y;
        end
      end
      OP_DELTA_X: t_q <= yaw_sum;
      OP_WRAP: begin
        if (wrap_hi) begin
          t_q <= t_q - $signed({6'b0, YawFull});
        end else if (wrap_lo) begin
          t_q <= t_q + $signed({6'b0, YawFull});
        end
      end
      OP_LOAD_YAW: begin
        x_q   <= CordicX0;
        y_q   <= '0;
        z_q   <= {ysel, 12'b0};
        neg_q <= neg_d;
      end
      OP_ROTATE: begin
        if (!z_q[29]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_ext;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_ext;
        end
      end
      OP_LOAD_PITCH: begin
        cos_yaw_q <= neg_q ? -x_q : x_q;
        sin_yaw_q <= neg_q ? -y_q : y_q;
        x_q       <= CordicX0;
        y_q       <= '0;
        z_q       <= {{2{pitch_q[15]}}, pitch_q, 12'b0};
      end
      OP_MUL_X: begin
        prod_q  <= prod_w;
        dir_y_q <= dir_y_d;
      end
      OP_MUL_Z: begin
        dir_x_q <= mld_dir_round(prod_q);
        prod_q  <= prod_w;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_dx_q    <= dir_x_q;
          out_dy_q    <= dir_y_q;
          out_dz_q    <= mld_dir_round(prod_q);
          out_yaw_q   <= yaw_q;
          out_pitch_q <= pitch_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.dir_x     = out_dx_q;
  assign out_o.dir_y     = out_dy_q;
  assign out_o.dir_z     = out_dz_q;
  assign out_o.yaw_now   = out_yaw_q;
  assign out_o.pitch_now = out_pitch_q;

  a_accept_starts_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pc_q == PcDeltaX))
    else $error("accepted item did not start the delta step");

  a_yaw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_q < YawFull)
    else $error("yaw left its wrapped range");

  a_pitch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pitch_q <= PitchLimit) && (pitch_q >= -PitchLimit))
    else $error("pitch left its clamped range");

  a_iter_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_ROTATE) |-> (iter_q <= LastIter))
    else $error("rotation step count overran");

endmodule
